// ----- hw/rtl/uer_pkg.sv -----
package uer_pkg;

    localparam int CHANNELS   = 6;
    localparam int TIME_BITS  = 32;
    localparam int KIND_W     = 2;
    localparam int CH_W       = 3;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int OUT_W      = 32;
    localparam int DIV_W      = 16;
    localparam int TRIG_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = $clog2(TIME_BITS);

    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ECHO    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRIGGER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 2'd1;

    localparam logic [DIV_W-1:0]  DIVISOR_RESET = 16'd58;
    localparam logic [TRIG_W-1:0] TRIGGER_RESET = 10'd10;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_step;
        logic load_out;
    } uer_cmd_t;

    typedef struct packed {
        logic needs_div;
        logic out_free;
    } uer_sts_t;

endpackage

// ----- hw/rtl/uer_ifs.sv -----
interface uer_item_if;
    logic                        valid;
    logic                        ready;
    logic [uer_pkg::KIND_W-1:0]  kind;
    logic [uer_pkg::CH_W-1:0]    channel;

    modport source (output valid, kind, channel, input ready);
    modport sink   (input valid, kind, channel, output ready);
endinterface

interface uer_result_if;
    logic                        valid;
    logic                        ready;
    logic                        trigger_level;
    logic                        measure_done;
    logic [uer_pkg::CH_W-1:0]    channel_out;
    logic [uer_pkg::OUT_W-1:0]   pulse_width;
    logic [uer_pkg::OUT_W-1:0]   distance;

    modport source (output valid, trigger_level, measure_done, channel_out, pulse_width,
                    distance, input ready);
    modport sink   (input valid, trigger_level, measure_done, channel_out, pulse_width,
                    distance, output ready);
endinterface

interface uer_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [uer_pkg::CFG_IDX_W-1:0]   index;
    logic [uer_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/uer_datapath.sv -----
module uer_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  uer_pkg::uer_cmd_t                cmd,
    output uer_pkg::uer_sts_t                sts,
    input  logic [uer_pkg::KIND_W-1:0]       kind,
    input  logic [uer_pkg::CH_W-1:0]         channel,
    input  logic                             cfg_valid,
    input  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic                             trigger_level,
    output logic                             measure_done,
    output logic [uer_pkg::CH_W-1:0]         channel_out,
    output logic [uer_pkg::OUT_W-1:0]        pulse_width,
    output logic [uer_pkg::OUT_W-1:0]        distance
);

    logic [uer_pkg::DIV_W-1:0]      divisor_reg;
    logic [uer_pkg::TRIG_W-1:0]     trig_ticks_reg;
    logic [uer_pkg::TIME_BITS-1:0]  time_reg;
    logic [uer_pkg::TRIG_W-1:0]     trig_rem_reg;
    logic                           echo_high_reg [uer_pkg::CHANNELS];
    logic [uer_pkg::TIME_BITS-1:0]  stamp_reg     [uer_pkg::CHANNELS];
    logic [uer_pkg::TIME_BITS-1:0]  width_reg     [uer_pkg::CHANNELS];

    logic [uer_pkg::KIND_W-1:0]     kind_reg;
    logic [uer_pkg::CH_W-1:0]       ch_reg;
    logic                           done_reg;

    logic [uer_pkg::DIV_W-1:0]      rem_reg;
    logic [uer_pkg::TIME_BITS-1:0]  quo_reg;

    logic                           out_valid_reg;
    logic                           trig_out_reg;
    logic                           done_out_reg;
    logic [uer_pkg::CH_W-1:0]       ch_out_reg;
    logic [uer_pkg::OUT_W-1:0]      width_out_reg;
    logic [uer_pkg::OUT_W-1:0]      dist_out_reg;

    logic                           in_range;
    logic [uer_pkg::CH_IDX_W-1:0]   in_idx;
    logic                           echo_hit;
    logic                           item_range;
    logic [uer_pkg::CH_IDX_W-1:0]   item_idx;
    logic                           chan_kind;
    logic [uer_pkg::DIV_W:0]        trial;
    logic [uer_pkg::DIV_W:0]        diff;
    logic                           q_bit;

    assign in_range   = int'(channel) < uer_pkg::CHANNELS;
    assign in_idx     = channel[uer_pkg::CH_IDX_W-1:0];
    assign echo_hit   = cmd.accept && (kind == uer_pkg::KIND_ECHO) && in_range;
    assign item_range = int'(ch_reg) < uer_pkg::CHANNELS;
    assign item_idx   = ch_reg[uer_pkg::CH_IDX_W-1:0];
    assign chan_kind  = (kind_reg == uer_pkg::KIND_ECHO) || (kind_reg == uer_pkg::KIND_READ);

    assign sts.needs_div = chan_kind && item_range;
    assign sts.out_free  = !out_valid_reg || out_ready;

    // restoring divide; a zero divisor yields all ones on its own
    assign trial = {rem_reg, quo_reg[uer_pkg::TIME_BITS-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign q_bit = trial >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg    <= uer_pkg::DIVISOR_RESET;
            trig_ticks_reg <= uer_pkg::TRIGGER_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                uer_pkg::REG_DIVISOR: divisor_reg    <= cfg_data;
                uer_pkg::REG_TRIGGER: trig_ticks_reg <= cfg_data[uer_pkg::TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg     <= '0;
            trig_rem_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (kind == uer_pkg::KIND_TICK)
            begin
                time_reg <= time_reg + 1'b1;
                if (trig_rem_reg != '0)
                begin
                    trig_rem_reg <= trig_rem_reg - 1'b1;
                end
            end
            else if (kind == uer_pkg::KIND_TRIGGER)
            begin
                trig_rem_reg <= trig_ticks_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < uer_pkg::CHANNELS; i++)
            begin
                echo_high_reg[i] <= 1'b0;
                stamp_reg[i]     <= '0;
                width_reg[i]     <= '0;
            end
        end
        else if (echo_hit)
        begin
            echo_high_reg[in_idx] <= !echo_high_reg[in_idx];
            if (!echo_high_reg[in_idx])
            begin
                stamp_reg[in_idx] <= time_reg;
            end
            else
            begin
                width_reg[in_idx] <= time_reg - stamp_reg[in_idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= kind;
            ch_reg   <= channel;
            done_reg <= echo_hit && echo_high_reg[in_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= width_reg[item_idx];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? diff[uer_pkg::DIV_W-1:0] : trial[uer_pkg::DIV_W-1:0];
            quo_reg <= {quo_reg[uer_pkg::TIME_BITS-2:0], q_bit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            trig_out_reg  <= trig_rem_reg != '0;
            done_out_reg  <= done_reg;
            ch_out_reg    <= chan_kind ? ch_reg : '0;
            width_out_reg <= sts.needs_div ? uer_pkg::OUT_W'(width_reg[item_idx]) : '0;
            dist_out_reg  <= sts.needs_div ? uer_pkg::OUT_W'(quo_reg) : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign trigger_level = trig_out_reg;
    assign measure_done  = done_out_reg;
    assign channel_out   = ch_out_reg;
    assign pulse_width   = width_out_reg;
    assign distance      = dist_out_reg;

    a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result register overwritten while held");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("result not presented after load");

    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && kind == uer_pkg::KIND_TICK |=> time_reg == $past(time_reg) + 1'b1)
        else $error("time counter did not advance on tick");

endmodule

// ----- hw/rtl/uer_ctrl.sv -----
module uer_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  uer_pkg::uer_sts_t  sts,
    output uer_pkg::uer_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_PEND  = 2'd3;

    localparam logic [uer_pkg::CNT_W-1:0] CNT_LAST = uer_pkg::CNT_W'(uer_pkg::TIME_BITS - 1);

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [uer_pkg::CNT_W-1:0]  cnt_reg;
    logic [uer_pkg::CNT_W-1:0]  cnt_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd.accept    = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (sts.needs_div)
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_PEND;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_PEND;
                end
            end
            S_PEND:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && cnt_reg == CNT_LAST |=> state_reg == S_PEND)
        else $error("divide did not finish after full count");

    a_skip_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_START && !sts.needs_div |=> state_reg == S_PEND)
        else $error("item without divide did not go to result");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == S_START)
        else $error("accepted word not processed");

endmodule

// ----- hw/rtl/ultrasonic_echo_ranger.sv -----
// Multi-channel ultrasonic echo ranger.
// item (sink): one word per event: kind 0 is a one-microsecond tick, 1 an echo
//   edge on channel, 2 starts the trigger pulse, 3 reads a channel's distance.
// result (source): exactly one word per item: trigger level after the item,
//   measurement-done flag, channel, last pulse width and width / divisor.
// cfg (sink): always ready; index 0 writes the distance divisor, index 1 the
//   trigger length in ticks; other indexes are dropped. Write only while idle.
// Timing: ticks and trigger items pass from acceptance through the START and PEND
//   states to the result register; echo and read items on a valid channel run a
//   one-bit-per-cycle restoring divider between START and PEND. One item is worked
//   on at a time: a new item is accepted only once the last one is in the result register.
// The result register lets the next item be accepted while a word waits; a
//   stalled receiver holds the block only once a second result is ready.
// Reset clears the time counter, trigger countdown, echo levels, stamps and
//   widths, and loads the register defaults (divisor 58, trigger 10 ticks).
module ultrasonic_echo_ranger
(
    input  logic          clk,
    input  logic          rst_n,
    uer_item_if.sink      item,
    uer_result_if.source  result,
    uer_cfg_if.sink       cfg
);

    uer_pkg::uer_cmd_t  cmd;
    uer_pkg::uer_sts_t  sts;

    assign cfg.ready = 1'b1;

    uer_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    uer_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (item.kind),
        .channel       (item.channel),
        .cfg_valid     (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .trigger_level (result.trigger_level),
        .measure_done  (result.measure_done),
        .channel_out   (result.channel_out),
        .pulse_width   (result.pulse_width),
        .distance      (result.distance)
    );

endmodule

// ----- verif/ultrasonic_echo_ranger_tb.sv -----
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_tb;

    localparam logic [uer_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
    localparam logic [uer_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 200;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_SHOWN     = 10;

    typedef struct packed {
        logic                      trig;
        logic                      done;
        logic [uer_pkg::CH_W-1:0]  chan;
        logic [uer_pkg::OUT_W-1:0] width;
        logic [uer_pkg::OUT_W-1:0] distance;
    } range_word_t;

    typedef struct packed {
        logic [uer_pkg::KIND_W-1:0] kind;
        logic [uer_pkg::CH_W-1:0]   ch;
        logic                       typed;
        range_word_t                want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    uer_item_if   item();
    uer_result_if result();
    uer_cfg_if    cfg();

    ultrasonic_echo_ranger DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    // mirror of the ranger
    logic [uer_pkg::DIV_W-1:0]     divisor;
    logic [uer_pkg::TRIG_W-1:0]    trig_len;
    logic [uer_pkg::TIME_BITS-1:0] usec_now;
    logic [uer_pkg::TRIG_W-1:0]    trig_left;
    logic                          echo_up    [uer_pkg::CHANNELS];
    logic [uer_pkg::TIME_BITS-1:0] rise_stamp [uer_pkg::CHANNELS];
    logic [uer_pkg::TIME_BITS-1:0] width_mem  [uer_pkg::CHANNELS];

    range_word_t pending_ranges[$];
    stim_row_t   dir_rows[$];
    range_word_t got_w;
    range_word_t want_w;

    int errors     = 0;
    int cycles     = 0;
    int items_sent = 0;
    int hold_left  = 0;
    int sink_gap   = 0;
    bit src_idle   = 1'b1;
    bit sink_idle  = 1'b1;

    function automatic logic [uer_pkg::OUT_W-1:0] to_distance(
        input logic [uer_pkg::TIME_BITS-1:0] w);
        if (divisor == '0)
            return '1;
        return w / divisor;
    endfunction

    function automatic range_word_t advance_ranger(input logic [uer_pkg::KIND_W-1:0] kind,
                                                   input logic [uer_pkg::CH_W-1:0] ch);
        range_word_t r;
        r = '0;
        if (kind == uer_pkg::KIND_TICK)
        begin
            usec_now = usec_now + 1'b1;
            if (trig_left != '0)
                trig_left = trig_left - 1'b1;
        end
        else if (kind == uer_pkg::KIND_TRIGGER)
        begin
            trig_left = trig_len;
        end
        else
        begin
            r.chan = ch;
            if (ch < uer_pkg::CHANNELS)
            begin
                if (kind == uer_pkg::KIND_ECHO)
                begin
                    if (!echo_up[ch])
                    begin
                        echo_up[ch]    = 1'b1;
                        rise_stamp[ch] = usec_now;
                    end
                    else
                    begin
                        echo_up[ch]   = 1'b0;
                        width_mem[ch] = usec_now - rise_stamp[ch];
                        r.done        = 1'b1;
                    end
                end
                r.width    = width_mem[ch];
                r.distance = to_distance(width_mem[ch]);
            end
        end
        r.trig = (trig_left != '0);
        return r;
    endfunction

    task automatic add_row(input logic [uer_pkg::KIND_W-1:0] kind,
                           input logic [uer_pkg::CH_W-1:0] ch,
                           input logic typed, input logic trig, input logic done,
                           input logic [uer_pkg::CH_W-1:0] chan,
                           input logic [uer_pkg::OUT_W-1:0] width,
                           input logic [uer_pkg::OUT_W-1:0] distance);
        stim_row_t row;
        row.kind          = kind;
        row.ch            = ch;
        row.typed         = typed;
        row.want.trig     = trig;
        row.want.done     = done;
        row.want.chan     = chan;
        row.want.width    = width;
        row.want.distance = distance;
        dir_rows.push_back(row);
    endtask

    task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                             input logic [uer_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        if (idx == uer_pkg::REG_DIVISOR)
            divisor = value;
        else if (idx == uer_pkg::REG_TRIGGER)
            trig_len = value[uer_pkg::TRIG_W-1:0];
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_item(input logic [uer_pkg::KIND_W-1:0] kind,
                             input logic [uer_pkg::CH_W-1:0] ch,
                             input logic typed, input range_word_t want);
        range_word_t r;
        @(negedge clk);
        if (src_idle && $urandom_range(0, 5) == 0)
        begin
            item.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        item.valid   <= 1'b1;
        item.kind    <= kind;
        item.channel <= ch;
        do @(posedge clk); while (!item.ready);
        r = advance_ranger(kind, ch);
        pending_ranges.push_back(typed ? want : r);
        items_sent++;
    endtask

    task automatic random_item();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 80) : 1;
            repeat (n) send_item(uer_pkg::KIND_TICK, uer_pkg::CH_W'($urandom_range(0, 7)),
                                 1'b0, '0);
        end
        else if (pick < 75)
            send_item(uer_pkg::KIND_ECHO,
                      uer_pkg::CH_W'($urandom_range(0, uer_pkg::CHANNELS - 1)), 1'b0, '0);
        else if (pick < 80)
            send_item(uer_pkg::KIND_TRIGGER, uer_pkg::CH_W'($urandom_range(0, 7)), 1'b0, '0);
        else if (pick < 93)
            send_item(uer_pkg::KIND_READ,
                      uer_pkg::CH_W'($urandom_range(0, uer_pkg::CHANNELS - 1)), 1'b0, '0);
        else
            send_item($urandom_range(0, 1) ? uer_pkg::KIND_ECHO : uer_pkg::KIND_READ,
                      uer_pkg::CH_W'($urandom_range(0, 7)), 1'b0, '0);
    endtask

    task automatic wait_drained();
        while (pending_ranges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("ultrasonic_echo_ranger verification failed");
            $finish;
        end
    end

    // result sink: random stalls plus a long hold-off on request
    initial
    begin
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result.ready <= 1'b0;
                hold_left--;
            end
            else if (sink_gap > 0)
            begin
                result.ready <= 1'b0;
                sink_gap--;
            end
            else if (sink_idle && $urandom_range(0, 7) == 0)
            begin
                result.ready <= 1'b0;
                sink_gap = $urandom_range(0, 5);
            end
            else
                result.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            got_w = {result.trigger_level, result.measure_done, result.channel_out,
                     result.pulse_width, result.distance};
            if (pending_ranges.size() == 0)
            begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected result word: trig %b done %b ch %0d width %0d dist %0d",
                             got_w.trig, got_w.done, got_w.chan, got_w.width, got_w.distance);
            end
            else
            begin
                want_w = pending_ranges.pop_front();
                if (got_w.trig !== want_w.trig || got_w.done !== want_w.done ||
                    got_w.chan !== want_w.chan || got_w.width !== want_w.width ||
                    got_w.distance !== want_w.distance)
                begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display({"mismatch exp/act: trig %b/%b done %b/%b ch %0d/%0d ",
                                  "width %0d/%0d dist %0d/%0d"},
                                 want_w.trig, got_w.trig, want_w.done, got_w.done,
                                 want_w.chan, got_w.chan, want_w.width, got_w.width,
                                 want_w.distance, got_w.distance);
                end
            end
        end
    end

    initial
    begin
        int limit;
        rst_n        = 1'b0;
        item.valid   = 1'b0;
        item.kind    = uer_pkg::KIND_TICK;
        item.channel = '0;
        cfg.valid    = 1'b0;
        cfg.index    = uer_pkg::REG_DIVISOR;
        cfg.data     = '0;
        divisor      = uer_pkg::DIVISOR_RESET;
        trig_len     = uer_pkg::TRIGGER_RESET;
        usec_now     = '0;
        trig_left    = '0;
        for (int c = 0; c < uer_pkg::CHANNELS; c++)
        begin
            echo_up[c]    = 1'b0;
            rise_stamp[c] = '0;
            width_mem[c]  = '0;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // kind, channel, typed, trig, done, chan, width, distance
        add_row(uer_pkg::KIND_READ,    3'd0, 1'b1, 1'b0, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_READ,    3'd7, 1'b1, 1'b0, 1'b0, 3'd7, 0, 0);
        add_row(uer_pkg::KIND_ECHO,    3'd6, 1'b1, 1'b0, 1'b0, 3'd6, 0, 0);
        add_row(uer_pkg::KIND_ECHO,    3'd7, 1'b1, 1'b0, 1'b0, 3'd7, 0, 0);
        add_row(uer_pkg::KIND_TRIGGER, 3'd0, 1'b1, 1'b1, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_ECHO,    3'd0, 1'b1, 1'b1, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_TICK,    3'd3, 1'b1, 1'b1, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_TICK,    3'd0, 1'b0, 1'b0, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_ECHO,    3'd0, 1'b0, 1'b0, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_ECHO,    3'd5, 1'b0, 1'b0, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_TRIGGER, 3'd5, 1'b0, 1'b0, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_TICK,    3'd7, 1'b0, 1'b0, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_ECHO,    3'd5, 1'b0, 1'b0, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_READ,    3'd5, 1'b0, 1'b0, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_ECHO,    3'd1, 1'b0, 1'b0, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_ECHO,    3'd1, 1'b0, 1'b0, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_READ,    3'd6, 1'b0, 1'b0, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_ECHO,    3'd2, 1'b0, 1'b0, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_ECHO,    3'd3, 1'b0, 1'b0, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_ECHO,    3'd4, 1'b0, 1'b0, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_TICK,    3'd1, 1'b0, 1'b0, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_ECHO,    3'd4, 1'b0, 1'b0, 1'b0, 3'd0, 0, 0);
        add_row(uer_pkg::KIND_READ,    3'd4, 1'b0, 1'b0, 1'b0, 3'd0, 0, 0);

        foreach (dir_rows[i])
            send_item(dir_rows[i].kind, dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            @(negedge clk);
            item.valid <= 1'b0;
            wait_drained();
            case (p)
                0:
                begin
                    write_reg(uer_pkg::REG_DIVISOR, 16'd1);
                    write_reg(uer_pkg::REG_TRIGGER, 16'd1);
                end
                1:
                begin
                    write_reg(uer_pkg::REG_DIVISOR, 16'hFFFF);
                    write_reg(uer_pkg::REG_TRIGGER, 16'hFFFF);
                    write_reg(REG_UNMAPPED_2, 16'h0000);
                end
                2:
                begin
                    write_reg(uer_pkg::REG_DIVISOR, 16'd0);
                    write_reg(uer_pkg::REG_TRIGGER, 16'd0);
                    write_reg(REG_UNMAPPED_3, 16'hFFFF);
                end
                3:
                begin
                    write_reg(uer_pkg::REG_DIVISOR, uer_pkg::DIVISOR_RESET);
                    write_reg(uer_pkg::REG_TRIGGER,
                              uer_pkg::CFG_DATA_W'(uer_pkg::TRIGGER_RESET));
                end
                default:
                begin
                    write_reg(uer_pkg::REG_DIVISOR, uer_pkg::CFG_DATA_W'(
                              ($urandom_range(0, 3) == 0) ?
                              $urandom_range(1, 65535) : $urandom_range(1, 100)));
                    write_reg(uer_pkg::REG_TRIGGER, uer_pkg::CFG_DATA_W'(
                              ($urandom_range(0, 3) == 0) ?
                              $urandom_range(1, 1023) : $urandom_range(1, 40)));
                end
            endcase
            src_idle  = (p < PHASES - 1) && (p < 2 || $urandom_range(0, 3) != 0);
            sink_idle = (p < PHASES - 1) && (p < 2 || $urandom_range(0, 3) != 0);
            // long receiver hold-off so the block backs up and stalls its input
            if (p == 2)
                hold_left = HOLD_CYCLES;
            limit = items_sent + PHASE_ITEMS;
            while (items_sent < limit)
                random_item();
        end

        @(negedge clk);
        item.valid <= 1'b0;
        wait_drained();

        if (errors == 0)
            $display("ultrasonic_echo_ranger verification clean");
        else
            $display("ultrasonic_echo_ranger verification failed");
        $finish;
    end

endmodule
